// ----- sv/iocsde_pkg.sv -----
// ----------------------------------------------------------------------------
// iocsde_pkg: shared types and constants for the input channel conditioner
// Register indexes, event codes, sequencer states and the request and
// response structs of the serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

package iocsde_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ProdW   = 2 * DataW;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_NUMERATOR   = 3'd0,
    REG_DENOMINATOR = 3'd1,
    REG_OFFSET      = 3'd2,
    REG_LOCKOUT     = 3'd3,
    REG_KIND        = 3'd4
  } cfg_reg_e;

  // Event codes carried in event_kind.
  typedef enum logic [1:0] {
    EV_CHANGED = 2'd0,
    EV_RISING  = 2'd1,
    EV_FALLING = 2'd2,
    EV_FAULT   = 2'd3
  } event_kind_e;

  // Channel kind register values.
  localparam logic KIND_DIGITAL = 1'b0;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ABS,
    S_DIV,
    S_FIX,
    S_EMIT
  } state_e;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- sv/iocsde_if.sv -----
// ----------------------------------------------------------------------------
// iocsde_if: channel interfaces of the input channel conditioner
// Valid/ready channels for readings, events and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Polled reading channel.
interface iocsde_in_if import iocsde_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] raw_sample;
  logic             read_failed;
  logic [DataW-1:0] time_ms;

  modport source (output valid, raw_sample, read_failed, time_ms, input ready);
  modport sink   (input valid, raw_sample, read_failed, time_ms, output ready);
endinterface

// Event channel.
interface iocsde_out_if import iocsde_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       event_kind;
  logic [DataW-1:0] sample_value;
  logic             fault_flag;
  logic [DataW-1:0] change_time;

  modport source (output valid, event_kind, sample_value, fault_flag, change_time,
                  input ready);
  modport sink   (input valid, event_kind, sample_value, fault_flag, change_time,
                  output ready);
endinterface

// Configuration write channel.
interface iocsde_cfg_if import iocsde_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/io_channel_scale_debounce_edge.sv -----
// ----------------------------------------------------------------------------
// io_channel_scale_debounce_edge: conditioner for one polled input channel
// Scales each reading, applies change detection and a lockout time, and
// reports changed, rising, falling and fault events.
// ----------------------------------------------------------------------------
// One reading is taken at a time. A good reading goes from its transaction to
// its event through these steps: multiply, take magnitudes, run the serial
// divider (two quotient bits per cycle) until its completion, sign and offset
// the quotient, and decide. A failed read goes straight to the decide step.
// The block is ready again in the cycle after the event is loaded, so it does
// not take a new reading before it is through with the last one. The block
// accepts a new reading once the previous event sits in the output register,
// and it waits in its decide step only while that register is still full.
// Configuration writes are always taken at once and must only be made while
// the block is idle.
`default_nettype none

module io_channel_scale_debounce_edge import iocsde_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  iocsde_cfg_if.sink  cfg_i,
  iocsde_in_if.sink   in_i,
  iocsde_out_if.source out_o
);

  state_e state_q, state_d;

  // Configuration registers.
  logic [DataW-1:0] num_q, den_q, offset_q, lockout_q;
  logic             kind_q;

  // Held channel state.
  logic [DataW-1:0] held_value_q, held_value_d;
  logic             held_fault_q, held_fault_d;
  logic [DataW-1:0] last_change_q, last_change_d;

  // Latched reading and intermediate values.
  logic [DataW-1:0] raw_q, time_q;
  logic             failed_q;
  logic [ProdW-1:0] prod_q;
  logic             neg_q;
  logic [DataW-1:0] value_q;

  // Output register.
  logic             out_valid_q, out_valid_d;
  event_kind_e      out_kind_q;
  logic [DataW-1:0] out_value_q, out_time_q;
  logic             out_fault_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             in_acc;
  logic             load;
  logic             emit;
  logic             locked;
  logic [DataW-1:0] elapsed;
  logic [DataW-1:0] den_mag;
  logic             den_neg;
  event_kind_e      kind;
  logic [DataW-1:0] quot_signed;

  assign in_acc      = in_i.valid & in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Divisor magnitude; a zero denominator counts as one.
  assign den_neg = den_q[DataW-1];
  always_comb begin
    if (den_q == '0) begin
      den_mag = DataW'(1);
    end else if (den_neg) begin
      den_mag = -den_q;
    end else begin
      den_mag = den_q;
    end
  end

  // Divider request, issued in the magnitude step.
  assign div_req.start    = (state_q == S_ABS);
  assign div_req.dividend = prod_q[ProdW-1] ? -prod_q : prod_q;
  assign div_req.divisor  = den_mag;

  iocsde_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Signed quotient, low word only.
  assign quot_signed = neg_q ? -div_rsp.quotient[DataW-1:0] : div_rsp.quotient[DataW-1:0];

  // Change, lockout and edge decisions.
  assign elapsed = time_q - last_change_q;
  assign locked  = (lockout_q != '0) && (elapsed < lockout_q);
  assign emit    = failed_q ||
                   (((value_q != held_value_q) || held_fault_q) && !locked);

  always_comb begin
    kind = EV_CHANGED;
    if (failed_q) begin
      kind = EV_FAULT;
    end else if (kind_q == KIND_DIGITAL) begin
      if ((held_value_q == '0) && (value_q != '0)) begin
        kind = EV_RISING;
      end else if ((held_value_q != '0) && (value_q == '0)) begin
        kind = EV_FALLING;
      end
    end
  end

  assign load = (state_q == S_EMIT) && emit && (!out_valid_q || out_o.ready);

  // Sequencer next state and held-state updates.
  always_comb begin
    state_d       = state_q;
    held_value_d  = held_value_q;
    held_fault_d  = held_fault_q;
    last_change_d = last_change_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = in_i.read_failed ? S_EMIT : S_MUL;
        end
      end
      S_MUL: state_d = S_ABS;
      S_ABS: state_d = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_FIX;
        end
      end
      S_FIX: state_d = S_EMIT;
      S_EMIT: begin
        if (!emit) begin
          state_d = S_IDLE;
        end else if (load) begin
          state_d = S_IDLE;
          if (failed_q) begin
            held_fault_d = 1'b1;
          end else begin
            held_value_d  = value_q;
            held_fault_d  = 1'b0;
            last_change_d = time_q;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid tracking.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control, configuration and held state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      num_q         <= DataW'(1);
      den_q         <= DataW'(1);
      offset_q      <= '0;
      lockout_q     <= '0;
      kind_q        <= KIND_DIGITAL;
      held_value_q  <= '0;
      held_fault_q  <= 1'b0;
      last_change_q <= '0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      held_value_q  <= held_value_d;
      held_fault_q  <= held_fault_d;
      last_change_q <= last_change_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          REG_NUMERATOR:   num_q     <= cfg_i.data;
          REG_DENOMINATOR: den_q     <= cfg_i.data;
          REG_OFFSET:      offset_q  <= cfg_i.data;
          REG_LOCKOUT:     lockout_q <= cfg_i.data;
          REG_KIND:        kind_q    <= cfg_i.data[0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_q    <= in_i.raw_sample;
      failed_q <= in_i.read_failed;
      time_q   <= in_i.time_ms;
    end
    if (state_q == S_MUL) begin
      prod_q <= ProdW'($signed(raw_q) * $signed(num_q));
    end
    if (state_q == S_ABS) begin
      neg_q <= prod_q[ProdW-1] ^ den_neg;
    end
    if (state_q == S_FIX) begin
      value_q <= quot_signed + offset_q;
    end
    if (load) begin
      out_kind_q  <= kind;
      out_value_q <= failed_q ? held_value_q : value_q;
      out_fault_q <= failed_q;
      out_time_q  <= failed_q ? last_change_q : time_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.event_kind   = out_kind_q;
  assign out_o.sample_value = out_value_q;
  assign out_o.fault_flag   = out_fault_q;
  assign out_o.change_time  = out_time_q;

  // The divider only completes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider completed outside its wait state");

  // A fault event leaves the held fault flag set.
  a_fault_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && failed_q) |=> (held_fault_q && out_o.fault_flag))
    else $error("fault event did not set the fault flag");

  // A good-read event clears the fault and records its time.
  a_change_records: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !failed_q) |=> (!held_fault_q && (last_change_q == out_o.change_time)))
    else $error("change event did not update held state");

  // No new reading is taken while an event is still being decided.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> !in_i.ready)
    else $error("reading accepted during decision");

endmodule

`default_nettype wire

// ----- sv/iocsde_div.sv -----
// ----------------------------------------------------------------------------
// iocsde_div: serial unsigned divider
// Restoring division of a 64-bit magnitude by a 32-bit magnitude, two
// quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iocsde_div import iocsde_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int unsigned StepsPerCycle = 2;
  localparam int unsigned Cycles        = ProdW / StepsPerCycle;
  localparam int unsigned CntW          = $clog2(Cycles);

  logic [DataW-1:0] rem_q, rem_d;
  logic [ProdW-1:0] dq_q, dq_d;
  logic [DataW-1:0] den_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  // One restoring step: shift in the next dividend bit and try a subtract.
  function automatic logic [DataW+ProdW-1:0] div_step(
    input logic [DataW-1:0] rem,
    input logic [ProdW-1:0] dq,
    input logic [DataW-1:0] den
  );
    logic [DataW:0]   shifted;
    logic [DataW+1:0] diff;
    logic             ge;
    shifted = {rem, dq[ProdW-1]};
    diff    = {1'b0, shifted} - {2'b00, den};
    ge      = ~diff[DataW+1];
    return {(ge ? diff[DataW-1:0] : shifted[DataW-1:0]), dq[ProdW-2:0], ge};
  endfunction

  // Next state of the divider.
  always_comb begin
    logic [DataW+ProdW-1:0] s1;
    logic [DataW+ProdW-1:0] s2;
    rem_d  = rem_q;
    dq_d   = dq_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    s1     = div_step(rem_q, dq_q, den_q);
    s2     = div_step(s1[DataW+ProdW-1:ProdW], s1[ProdW-1:0], den_q);
    if (req_i.start) begin
      rem_d  = '0;
      dq_d   = req_i.dividend;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = s2[DataW+ProdW-1:ProdW];
      dq_d  = s2[ProdW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(Cycles - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    if (req_i.start) begin
      den_q <= req_i.divisor;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dq_q;

endmodule

`default_nettype wire

// ----- tb/iocsde_event_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iocsde_event_checker: event predictor and comparator for the channel
// conditioner
// Watches the configuration, reading and event channels. It keeps its own copy
// of the registers and the held value, fault and change time, predicts the
// event of every accepted reading and compares each event transaction, field
// by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module iocsde_event_checker import iocsde_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  iocsde_cfg_if cfg_mon,
  iocsde_in_if  reading_mon,
  iocsde_out_if event_mon,
  output int    events_owed_o,
  output int    fail_count_o
);

  typedef struct {
    event_kind_e      kind;
    logic [DataW-1:0] value;
    logic             fault;
    logic [DataW-1:0] stamp;
  } event_rec_t;

  // Register copies.
  logic [DataW-1:0] cfg_num;
  logic [DataW-1:0] cfg_den;
  logic [DataW-1:0] cfg_offset;
  logic [DataW-1:0] cfg_lockout;
  logic             cfg_kind;

  // Channel state as the block should hold it.
  logic [DataW-1:0] held_value;
  logic             held_fault;
  logic [DataW-1:0] last_change;

  event_rec_t       owed_events[$];
  int               errors;

  // Scaling: exact 64-bit product, division truncated toward zero, zero
  // denominator taken as one, quotient and offset wrapped to 32 bits.
  function automatic logic [DataW-1:0] scale_sample(input logic [DataW-1:0] raw);
    longint product;
    longint divisor;
    longint quotient;
    divisor  = (cfg_den == '0) ? 64'sd1 : longint'($signed(cfg_den));
    product  = longint'($signed(raw)) * longint'($signed(cfg_num));
    quotient = product / divisor;
    return quotient[DataW-1:0] + cfg_offset;
  endfunction

  // Works out the event, if any, that one reading causes and updates the state.
  function automatic void condition_reading(input logic [DataW-1:0] raw,
                                            input logic             failed,
                                            input logic [DataW-1:0] now);
    logic [DataW-1:0] scaled;
    event_kind_e      kind;
    if (failed) begin
      held_fault = 1'b1;
      owed_events.push_back('{EV_FAULT, held_value, held_fault, last_change});
      return;
    end
    scaled = scale_sample(raw);
    // An unchanged value is dropped unless it clears a held fault.
    if (scaled == held_value && !held_fault) return;
    // Lockout works on the elapsed time modulo 2^32.
    if (cfg_lockout != '0 && DataW'(now - last_change) < cfg_lockout) return;
    kind = EV_CHANGED;
    if (cfg_kind == KIND_DIGITAL) begin
      if (held_value == '0 && scaled != '0) kind = EV_RISING;
      else if (held_value != '0 && scaled == '0) kind = EV_FALLING;
    end
    held_value  = scaled;
    held_fault  = 1'b0;
    last_change = now;
    owed_events.push_back('{kind, held_value, held_fault, last_change});
  endfunction

  // Compares one event transaction with the oldest prediction.
  function automatic void check_event();
    event_rec_t owed;
    if (owed_events.size() == 0) begin
      $error("event transaction with none expected: event_kind %0d, sample_value %h",
             event_mon.event_kind, event_mon.sample_value);
      errors++;
      return;
    end
    owed = owed_events.pop_front();
    if (event_mon.event_kind !== owed.kind) begin
      $error("event_kind: expected %0d, actual %0d", owed.kind, event_mon.event_kind);
      errors++;
    end
    if (event_mon.sample_value !== owed.value) begin
      $error("sample_value: expected %h, actual %h", owed.value, event_mon.sample_value);
      errors++;
    end
    if (event_mon.fault_flag !== owed.fault) begin
      $error("fault_flag: expected %0d, actual %0d", owed.fault, event_mon.fault_flag);
      errors++;
    end
    if (event_mon.change_time !== owed.stamp) begin
      $error("change_time: expected %h, actual %h", owed.stamp, event_mon.change_time);
      errors++;
    end
  endfunction

  // Every channel is sampled at the clock edge where its transaction happens.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_num     = 32'd1;
      cfg_den     = 32'd1;
      cfg_offset  = '0;
      cfg_lockout = '0;
      cfg_kind    = KIND_DIGITAL;
      held_value  = '0;
      held_fault  = 1'b0;
      last_change = '0;
      owed_events.delete();
      errors = 0;
      events_owed_o <= 0;
      fail_count_o  <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_NUMERATOR:   cfg_num     = cfg_mon.data;
          REG_DENOMINATOR: cfg_den     = cfg_mon.data;
          REG_OFFSET:      cfg_offset  = cfg_mon.data;
          REG_LOCKOUT:     cfg_lockout = cfg_mon.data;
          REG_KIND:        cfg_kind    = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (reading_mon.valid && reading_mon.ready) begin
        condition_reading(reading_mon.raw_sample, reading_mon.read_failed,
                          reading_mon.time_ms);
      end
      if (event_mon.valid && event_mon.ready) check_event();
      events_owed_o <= owed_events.size();
      fail_count_o  <= errors;
    end
  end

endmodule

// ----- tb/io_channel_scale_debounce_edge_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_channel_scale_debounce_edge_test: top of the channel conditioner bench
// Drives directed readings and then phases of random readings under several
// register settings, with random gaps on the reading side and random stalls
// on the event side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module io_channel_scale_debounce_edge_test;
  import iocsde_pkg::*;

  localparam int               SettleCycles = 50;
  localparam int               LimitNs      = 5_000_000;
  localparam logic             KIND_ANALOG  = 1'b1;
  // Indexes that decode to no register.
  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

  logic             clk_i;
  logic             rst_ni;
  int               gap_odds;
  int               stall_odds;
  int               events_owed;
  int               check_fails;
  logic [DataW-1:0] stamp;
  logic [DataW-1:0] last_raw;

  iocsde_cfg_if cfg_bus ();
  iocsde_in_if  reading_bus ();
  iocsde_out_if event_bus ();

  io_channel_scale_debounce_edge u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (reading_bus),
    .out_o  (event_bus)
  );

  iocsde_event_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_mon       (cfg_bus),
    .reading_mon   (reading_bus),
    .event_mon     (event_bus),
    .events_owed_o (events_owed),
    .fail_count_o  (check_fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #LimitNs;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Event side: stalls in random bursts.
  initial begin
    int hold;
    hold = 0;
    event_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        event_bus.ready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
        hold = $urandom_range(0, 10);
        event_bus.ready <= 1'b0;
      end else begin
        event_bus.ready <= 1'b1;
      end
    end
  end

  // Leaves valid high so that writes can follow back to back.
  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [DataW-1:0]   data);
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_bus.ready);
  endtask

  // One reading transaction, sometimes after a random gap.
  task automatic send_reading(input logic [DataW-1:0] raw,
                              input logic             failed,
                              input logic [DataW-1:0] now);
    int pause;
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      pause = $urandom_range(1, 11);
      reading_bus.valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    reading_bus.raw_sample  <= raw;
    reading_bus.read_failed <= failed;
    reading_bus.time_ms     <= now;
    reading_bus.valid       <= 1'b1;
    do @(posedge clk_i); while (!reading_bus.ready);
  endtask

  // The first edge lets the checker count a reading taken at the last edge.
  task automatic wait_for_events();
    @(posedge clk_i);
    while (events_owed != 0) @(posedge clk_i);
  endtask

  // Drains the block, writes all registers, then sends random readings.
  task automatic run_phase(input logic [DataW-1:0] num,
                           input logic [DataW-1:0] den,
                           input logic [DataW-1:0] offset,
                           input logic [DataW-1:0] lockout,
                           input logic             kind,
                           input int               count);
    int unsigned      span;
    int               pick;
    logic [DataW-1:0] raw;
    logic [DataW-1:0] kind_word;
    logic             failed;
    reading_bus.valid <= 1'b0;
    wait_for_events();
    // A dropped reading may still be in the divider.
    repeat (SettleCycles) @(posedge clk_i);
    kind_word    = $urandom();
    kind_word[0] = kind;
    write_register(REG_NUMERATOR, num);
    write_register(REG_DENOMINATOR, den);
    write_register(REG_OFFSET, offset);
    write_register(REG_LOCKOUT, lockout);
    write_register(REG_KIND, kind_word);
    write_register(REG_SPARE_LO, $urandom());
    write_register(REG_SPARE_HI, $urandom());
    cfg_bus.valid <= 1'b0;

    // Time steps straddle the lockout so that both sides of it are hit.
    span = (lockout == '0) ? 6 : ((lockout > 1000) ? 1000 : 2 * lockout + 2);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: raw = '0;
        3, 4:    raw = $urandom_range(1, 3);
        5, 6:    raw = last_raw;
        7:       raw = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: raw = $urandom();
      endcase
      failed = ($urandom_range(0, 9) == 0);
      pick   = $urandom_range(0, 19);
      if (pick == 0) stamp = $urandom();
      else if (pick != 1) stamp = stamp + $urandom_range(0, span);
      last_raw = raw;
      send_reading(raw, failed, stamp);
    end
  endtask

  // Stimulus.
  initial begin
    rst_ni                  <= 1'b0;
    cfg_bus.valid           <= 1'b0;
    cfg_bus.index           <= '0;
    cfg_bus.data            <= '0;
    reading_bus.valid       <= 1'b0;
    reading_bus.raw_sample  <= '0;
    reading_bus.read_failed <= 1'b0;
    reading_bus.time_ms     <= '0;
    gap_odds   = 4;
    stall_odds = 5;
    stamp      = '0;
    last_raw   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed readings on the reset settings: digital, unity scale, no lockout.
    send_reading(32'h0000_0000, 1'b0, 32'd0);          // zero on zero: dropped
    send_reading(32'h0000_0001, 1'b0, 32'd1);          // rising
    send_reading(32'h0000_0001, 1'b0, 32'd2);          // unchanged: dropped
    send_reading(32'h0000_0000, 1'b0, 32'd3);          // falling
    send_reading(32'h0000_0005, 1'b0, 32'd4);          // rising
    send_reading(32'h0000_0007, 1'b0, 32'd5);          // changed
    send_reading(32'hFFFF_FFFF, 1'b1, 32'd6);          // fault
    send_reading(32'h0000_0007, 1'b1, 32'd7);          // repeated fault
    send_reading(32'h0000_0007, 1'b0, 32'd8);          // recovery at the same value
    send_reading(32'h7FFF_FFFF, 1'b0, 32'd9);
    send_reading(32'h8000_0000, 1'b0, 32'd10);
    send_reading(32'hFFFF_FFFF, 1'b0, 32'd11);
    send_reading(32'h0000_0000, 1'b0, 32'd12);         // falling
    send_reading(32'h0000_0002, 1'b0, 32'hFFFF_FFFF);  // rising at the top of time
    send_reading(32'h0000_0000, 1'b1, 32'd0);          // fault while zero
    send_reading(32'h0000_0000, 1'b0, 32'd1);          // recovery at zero
    send_reading(32'h8000_0000, 1'b1, 32'hFFFF_FFFF);  // fault at the top of time
    send_reading(32'h0000_0003, 1'b0, 32'd5);          // rising

    // Random phases over several settings.
    run_phase(32'd1, 32'd1, 32'd0, 32'd0, KIND_DIGITAL, 170);
    run_phase(32'd3, 32'd2, 32'hFFFF_FFFB, 32'd8, KIND_DIGITAL, 170);
    // Largest product, divided by minus one.
    run_phase(32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0, KIND_ANALOG, 80);
    gap_odds   = 0;
    stall_odds = 0;
    // Zero denominator and an offset that wraps.
    run_phase(32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd0, KIND_DIGITAL, 80);
    gap_odds   = 3;
    stall_odds = 3;
    // Longest lockout: only faults get through once a change is held.
    run_phase($urandom(), $urandom(), $urandom(), 32'hFFFF_FFFF, KIND_ANALOG, 60);
    run_phase(32'd0, 32'h8000_0000, 32'h8000_0000, 32'd3, KIND_DIGITAL, 60);
    gap_odds   = 6;
    stall_odds = 4;
    run_phase(32'd7, 32'hFFFF_FFFD, 32'd100, 32'd2, KIND_ANALOG, 170);
    // Closing stretch without idling.
    gap_odds   = 0;
    stall_odds = 0;
    run_phase(32'd1, 32'd1, 32'd0, 32'd0, KIND_DIGITAL, 150);

    reading_bus.valid <= 1'b0;
    wait_for_events();
    repeat (SettleCycles) @(posedge clk_i);
    if (check_fails == 0 && events_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
